FILE: rtl/cied_pkg.sv
package cied_pkg;

  localparam int MAX_LEN_DEF = 32;
  localparam int DIST_W = 6;
  localparam logic [DIST_W-1:0] DIST_MAX = 6'd63;

  localparam logic OP_FIRST = 1'b0;
  localparam logic OP_SECOND = 1'b1;

  typedef struct packed {
    logic       operation;
    logic [7:0] char_code;
    logic       has_char;
    logic       last;
  } in_item_t;

  typedef struct packed {
    logic [DIST_W-1:0] distance;
    logic              too_long;
  } out_item_t;

  function automatic logic [7:0] fold_case(input logic [7:0] c);
    logic [7:0] r;
    r = c;
    if (c >= 8'h41 && c <= 8'h5A) begin
      r = c + 8'd32;
    end
    return r;
  endfunction

endpackage

FILE: rtl/cied_cell.sv
module cied_cell import cied_pkg::*; #(
  parameter int CW = 6
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          ld_en,
  input  logic [7:0]    ld_ch,
  input  logic          init_en,
  input  logic [CW-1:0] init_val,
  input  logic          in_v,
  input  logic [7:0]    in_ch,
  input  logic [CW-1:0] in_left,
  input  logic [CW-1:0] in_diag,
  output logic          out_v,
  output logic [7:0]    out_ch,
  output logic [CW-1:0] out_left,
  output logic [CW-1:0] out_diag,
  output logic [CW-1:0] cost
);

  logic [7:0]    ch_r;
  logic [CW-1:0] val_r;
  logic          out_v_r;
  logic [7:0]    out_ch_r;
  logic [CW-1:0] out_left_r;
  logic [CW-1:0] out_diag_r;
  logic [CW:0]   up;
  logic [CW:0]   lf;
  logic [CW:0]   sb;
  logic [CW:0]   m1;
  logic [CW:0]   best;

  always_comb begin
    up = {1'b0, val_r} + (CW+1)'(1);
    lf = {1'b0, in_left} + (CW+1)'(1);
    sb = {1'b0, in_diag} + (CW+1)'(in_ch != ch_r);
    m1 = (lf < up) ? lf : up;
    best = (sb < m1) ? sb : m1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else begin
      out_v_r <= in_v;
    end
  end

  always_ff @(posedge clk) begin
    if (ld_en) begin
      ch_r <= ld_ch;
    end
    if (init_en) begin
      val_r <= init_val;
    end else if (in_v) begin
      val_r <= best[CW-1:0];
    end
    out_ch_r <= in_ch;
    out_left_r <= best[CW-1:0];
    out_diag_r <= val_r;
  end

  assign out_v = out_v_r;
  assign out_ch = out_ch_r;
  assign out_left = out_left_r;
  assign out_diag = out_diag_r;
  assign cost = val_r;

endmodule

FILE: rtl/case_insensitive_edit_distance.sv
// Case-insensitive Levenshtein distance between two byte strings of up to MAX_LEN characters.
// Send the first string as operation 0 items and then the second as operation 1 items, each
// closed by an item with last set; an empty string is one item with has_char low. The first
// string is kept in a row of MAX_LEN cells, one character and one cost entry per cell. Each
// character of the second string starts an update wave that moves one cell per cycle, and such
// an item holds the input until the wave has left the row. The final item of the second string
// holds it further until its result is registered, which waits while the previous result has
// not been taken. All other items do not hold the input. The result is registered once the wave
// of the final character has left the row.
module case_insensitive_edit_distance import cied_pkg::*; #(
  parameter int MAX_LEN = MAX_LEN_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_data
);

  localparam int CW = $clog2(MAX_LEN + 1);
  localparam int IW = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
  localparam int EW = (CW > DIST_W) ? CW : DIST_W;

  logic [CW-1:0] len_r, len_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          ovf_r, ovf_nxt;
  logic          loading_r, loading_nxt;
  logic          pend_r, pend_nxt;
  logic [CW-1:0] row0_r;
  logic          hd_v_r;
  logic [7:0]    hd_ch_r;
  logic [CW-1:0] hd_left_r;
  logic [CW-1:0] hd_diag_r;
  logic          out_valid_r;
  out_item_t     out_data_r;

  logic [MAX_LEN:0] tok_v;
  logic [7:0]       tok_ch   [MAX_LEN+1];
  logic [CW-1:0]    tok_left [MAX_LEN+1];
  logic [CW-1:0]    tok_diag [MAX_LEN+1];
  logic [CW-1:0]    cost_w   [MAX_LEN];

  logic          busy;
  logic          in_fire;
  logic          is_first;
  logic [7:0]    ch_f;
  logic [CW-1:0] len_eff;
  logic          ovf_eff;
  logic          ld_any;
  logic [IW-1:0] ld_idx;
  logic          init_en;
  logic          adv;
  logic          res_fire;
  logic [CW-1:0] len_m1;
  logic [CW-1:0] d_raw;
  logic [EW-1:0] d_ext;

  assign busy = |tok_v;
  assign in_ready = !busy && !pend_r;
  assign in_fire = in_valid && in_ready;
  assign is_first = (in_data.operation == OP_FIRST);
  assign ch_f = fold_case(in_data.char_code);
  assign len_eff = loading_r ? '0 : len_r;
  assign ovf_eff = loading_r ? 1'b0 : ovf_r;
  assign ld_any = in_fire && is_first && in_data.has_char && (len_eff < CW'(MAX_LEN));
  assign ld_idx = len_eff[IW-1:0];
  assign init_en = in_fire && is_first && in_data.last;
  assign adv = in_fire && !is_first && loading_r && in_data.has_char
               && (cnt_r < CW'(MAX_LEN));
  assign res_fire = pend_r && !busy && (!out_valid_r || out_ready);

  assign tok_v[0] = hd_v_r;
  assign tok_ch[0] = hd_ch_r;
  assign tok_left[0] = hd_left_r;
  assign tok_diag[0] = hd_diag_r;

  for (genvar i = 0; i < MAX_LEN; i++) begin : g_cell
    cied_cell #(.CW(CW)) u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .ld_en    (ld_any && (ld_idx == IW'(i))),
      .ld_ch    (ch_f),
      .init_en  (init_en),
      .init_val (CW'(i + 1)),
      .in_v     (tok_v[i]),
      .in_ch    (tok_ch[i]),
      .in_left  (tok_left[i]),
      .in_diag  (tok_diag[i]),
      .out_v    (tok_v[i+1]),
      .out_ch   (tok_ch[i+1]),
      .out_left (tok_left[i+1]),
      .out_diag (tok_diag[i+1]),
      .cost     (cost_w[i])
    );
  end

  always_comb begin
    len_nxt = len_r;
    cnt_nxt = cnt_r;
    ovf_nxt = ovf_r;
    loading_nxt = loading_r;
    pend_nxt = pend_r;
    if (in_fire) begin
      if (is_first) begin
        len_nxt = len_eff;
        ovf_nxt = ovf_eff;
        cnt_nxt = loading_r ? '0 : cnt_r;
        loading_nxt = 1'b0;
        if (in_data.has_char) begin
          if (len_eff < CW'(MAX_LEN)) begin
            len_nxt = len_eff + CW'(1);
          end else begin
            ovf_nxt = 1'b1;
          end
        end
        if (in_data.last) begin
          cnt_nxt = '0;
          loading_nxt = 1'b1;
        end
      end else if (loading_r) begin
        if (in_data.has_char) begin
          if (cnt_r < CW'(MAX_LEN)) begin
            cnt_nxt = cnt_r + CW'(1);
          end else begin
            ovf_nxt = 1'b1;
          end
        end
        if (in_data.last) begin
          pend_nxt = 1'b1;
        end
      end
    end
    if (res_fire) begin
      len_nxt = '0;
      cnt_nxt = '0;
      ovf_nxt = 1'b0;
      loading_nxt = 1'b0;
      pend_nxt = 1'b0;
    end
  end

  assign len_m1 = len_r - CW'(1);
  assign d_raw = (len_r == '0) ? row0_r : cost_w[len_m1[IW-1:0]];
  assign d_ext = EW'(d_raw);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_r <= '0;
      cnt_r <= '0;
      ovf_r <= 1'b0;
      loading_r <= 1'b0;
      pend_r <= 1'b0;
      hd_v_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      len_r <= len_nxt;
      cnt_r <= cnt_nxt;
      ovf_r <= ovf_nxt;
      loading_r <= loading_nxt;
      pend_r <= pend_nxt;
      hd_v_r <= adv;
      if (res_fire) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (init_en) begin
      row0_r <= '0;
    end else if (adv) begin
      row0_r <= cnt_r + CW'(1);
    end
    if (adv) begin
      hd_ch_r <= ch_f;
      hd_left_r <= cnt_r + CW'(1);
      hd_diag_r <= row0_r;
    end
    if (res_fire) begin
      out_data_r.distance <= (d_ext > EW'(DIST_MAX)) ? DIST_MAX : d_ext[DIST_W-1:0];
      out_data_r.too_long <= ovf_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data = out_data_r;

  a_one_wave: assert property (@(posedge clk) disable iff (!rst_n) $onehot0(tok_v))
    else $error("More than one update wave in the cell row.");

  a_wave_loaded: assert property (@(posedge clk) disable iff (!rst_n)
    hd_v_r |-> (loading_r && cnt_r != '0))
    else $error("Update wave started without a loaded first string.");

  a_pend_loaded: assert property (@(posedge clk) disable iff (!rst_n) pend_r |-> loading_r)
    else $error("Pending result without a loaded first string.");

  a_dist_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (32'(out_data.distance) <= MAX_LEN))
    else $error("Distance exceeds the maximum string length.");

endmodule
